>>> hw/rtl/bm25_pkg.sv
// Shared constants, field widths and codes of the BM25 term scorer.
// Used by the channel interfaces, the log2 unit and the top level.
package bm25_pkg;

    localparam int DOC_LEN_W  = 16;
    localparam int TF_W       = 16;
    localparam int DF_W       = 24;
    localparam int SCORE_W    = 24;
    localparam int STATUS_W   = 2;
    localparam int K1_W       = 16;
    localparam int B_W        = 17;
    localparam int AVG_W      = 24;
    localparam int N_W        = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int SCORE_FRAC_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF      = 24;

    // log2 fraction bits and ln 2 in Q30.
    localparam int LOG_FRAC   = 20;
    localparam int LN2_W      = 30;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
    localparam int IDF_SHIFT  = LOG_FRAC + 6;

    localparam logic [B_W-1:0]  ONE_Q16 = 17'd65536;
    localparam logic [K1_W:0]   K1_ONE  = 17'd4096;

    localparam int SCORE_MAX_MAG = 8388607;
    localparam int SCORE_MIN_MAG = 8388608;

    localparam logic [K1_W-1:0]  K1_RESET  = 16'd4915;
    localparam logic [B_W-1:0]   B_RESET   = 17'd49152;
    localparam logic [AVG_W-1:0] AVG_RESET = '0;
    localparam logic [N_W-1:0]   N_RESET   = '0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_COUNT = 2'd1,
        ST_ZERO_AVG   = 2'd2,
        ST_DF_OVER_N  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TF_SAT    = 2'd0,
        CFG_LEN_NORM  = 2'd1,
        CFG_AVG_LEN   = 2'd2,
        CFG_DOC_TOTAL = 2'd3
    } cfg_idx_t;

endpackage

>>> hw/rtl/bm25_item_if.sv
// Input channel of the BM25 scorer: one term-document pair per transaction.
// Depends on bm25_pkg for the field widths.
interface bm25_item_if;
    import bm25_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DOC_LEN_W-1:0] doc_len;
    logic [TF_W-1:0]      tf_count;
    logic [DF_W-1:0]      doc_freq;

    modport source (output valid, output doc_len, output tf_count, output doc_freq,
                    input ready);
    modport sink (input valid, input doc_len, input tf_count, input doc_freq,
                  output ready);
endinterface

>>> hw/rtl/bm25_result_if.sv
// Result channel of the BM25 scorer: one score and status per transaction.
// Depends on bm25_pkg for the field widths.
interface bm25_result_if;
    import bm25_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output score, output status, input ready);
    modport sink (input valid, input score, input status, output ready);
endinterface

>>> hw/rtl/bm25_cfg_if.sv
// Register write channel of the BM25 scorer.
// Depends on bm25_pkg for the index and data widths.
interface bm25_cfg_if;
    import bm25_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/bm25_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries an opaque side payload alongside; needs the quotient to fit in QW bits.
module bm25_div #(
    parameter int NW = 40,
    parameter int DW = 24,
    parameter int QW = 40,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quotient,
    output logic [SW-1:0] side_out
);
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] dsr_reg [QW];
    logic [SW-1:0] side_reg [QW];
    logic          vld_reg [QW];
    logic [DW-1:0] rem_init;

    // The dividend bits above the quotient width form the first partial remainder.
    generate
        if (NW > QW) begin : g_init_hi
            assign rem_init = DW'(dividend[NW-1:QW]);
        end else begin : g_init_zero
            assign rem_init = '0;
        end
    endgenerate

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW-1:0] r_in;
        logic [QW-1:0] z_in;
        logic [DW-1:0] d_in;
        logic [SW-1:0] s_in;
        logic          v_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (g == 0) begin : g_first
            assign r_in = rem_init;
            assign z_in = dividend[QW-1:0];
            assign d_in = divisor;
            assign s_in = side_in;
            assign v_in = in_valid;
        end else begin : g_next
            assign r_in = rem_reg[g-1];
            assign z_in = quo_reg[g-1];
            assign d_in = dsr_reg[g-1];
            assign s_in = side_reg[g-1];
            assign v_in = vld_reg[g-1];
        end

        always_comb
        begin
            trial    = {r_in, z_in[QW-1]};
            diff     = trial - {1'b0, d_in};
            ge       = (trial >= {1'b0, d_in});
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_next = {z_in[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g]  <= rem_next;
                quo_reg[g]  <= quo_next;
                dsr_reg[g]  <= d_in;
                side_reg[g] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quotient  = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];
endmodule

>>> hw/rtl/bm25_log2.sv
// Two-lane pipelined log2: leading-one stage, normalize stage, then one
// squaring stage per fraction bit. Depends on bm25_pkg for LOG_FRAC.
module bm25_log2 #(
    parameter int XW = 25,
    parameter int SW = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [XW-1:0]                        x_a,
    input  logic [XW-1:0]                        x_b,
    input  logic [SW-1:0]                        side_in,
    output logic                                 out_valid,
    output logic [$clog2(XW)+bm25_pkg::LOG_FRAC-1:0] log_a,
    output logic [$clog2(XW)+bm25_pkg::LOG_FRAC-1:0] log_b,
    output logic [SW-1:0]                        side_out
);
    import bm25_pkg::*;

    localparam int LW = $clog2(XW);
    localparam int MW = 31;
    localparam int NS = LOG_FRAC;

    function automatic logic [LW-1:0] lead_one(input logic [XW-1:0] x);
        logic [LW-1:0] r;
        r = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (x[i])
            begin
                r = LW'(i);
            end
        end
        return r;
    endfunction

    // Mantissa in [1,2) as Q30: x << (30 - lead), or x >> (lead - 30).
    function automatic logic [MW-1:0] normalize(input logic [XW-1:0] x,
                                                input logic [LW-1:0] lead);
        logic [XW+29:0] e;
        e = {x, 30'b0} >> lead;
        return e[MW-1:0];
    endfunction

    // One squaring step: upper bit is the next fraction bit.
    function automatic logic [MW:0] sq_step(input logic [MW-1:0] m);
        logic [2*MW-1:0] p;
        logic [MW:0]     t;
        p = (2*MW)'(m) * (2*MW)'(m);
        t = p[2*MW-1:30];
        if (t[MW])
        begin
            return {1'b1, t[MW:1]};
        end
        return {1'b0, t[MW-1:0]};
    endfunction

    logic          v0_reg;
    logic [XW-1:0] xa0_reg, xb0_reg;
    logic [LW-1:0] lda0_reg, ldb0_reg;
    logic [SW-1:0] side0_reg;

    logic [MW-1:0]   ma_reg [NS+1];
    logic [MW-1:0]   mb_reg [NS+1];
    logic [NS-1:0]   fa_reg [NS+1];
    logic [NS-1:0]   fb_reg [NS+1];
    logic [LW-1:0]   lda_reg [NS+1];
    logic [LW-1:0]   ldb_reg [NS+1];
    logic [SW-1:0]   side_reg [NS+1];
    logic            v_reg [NS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg   <= in_valid;
            v_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa0_reg     <= x_a;
            xb0_reg     <= x_b;
            lda0_reg    <= lead_one(x_a);
            ldb0_reg    <= lead_one(x_b);
            side0_reg   <= side_in;
            ma_reg[0]   <= normalize(xa0_reg, lda0_reg);
            mb_reg[0]   <= normalize(xb0_reg, ldb0_reg);
            fa_reg[0]   <= '0;
            fb_reg[0]   <= '0;
            lda_reg[0]  <= lda0_reg;
            ldb_reg[0]  <= ldb0_reg;
            side_reg[0] <= side0_reg;
        end
    end

    for (genvar g = 1; g <= NS; g++) begin : g_sq
        logic [MW:0] sa_next;
        logic [MW:0] sb_next;

        assign sa_next = sq_step(ma_reg[g-1]);
        assign sb_next = sq_step(mb_reg[g-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[g] <= v_reg[g-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ma_reg[g]   <= sa_next[MW-1:0];
                mb_reg[g]   <= sb_next[MW-1:0];
                fa_reg[g]   <= {fa_reg[g-1][NS-2:0], sa_next[MW]};
                fb_reg[g]   <= {fb_reg[g-1][NS-2:0], sb_next[MW]};
                lda_reg[g]  <= lda_reg[g-1];
                ldb_reg[g]  <= ldb_reg[g-1];
                side_reg[g] <= side_reg[g-1];
            end
        end
    end

    assign out_valid = v_reg[NS];
    assign log_a     = {lda_reg[NS], fa_reg[NS]};
    assign log_b     = {ldb_reg[NS], fb_reg[NS]};
    assign side_out  = side_reg[NS];
endmodule

>>> hw/rtl/bm25_term_score.sv
// BM25 term scorer. Pipeline: 101 register stages from the accepting edge to the
// valid result (2 prep stages, 22-stage log2 unit, 2 idf stages, 40-stage length
// divider, 3 denominator stages, 29-stage tf divider, 2 output stages, output
// register). Throughput: one item per cycle while the skid stage is empty; the
// divider pipelines, one quotient bit per stage, set most of the depth. Reset
// clears valid bits and loads the register defaults (k1 1.2, b 0.75).
module bm25_term_score #(
    parameter int SCORE_FRAC_BITS = bm25_pkg::SCORE_FRAC_BITS_DEF,
    parameter int COUNT_BITS      = bm25_pkg::COUNT_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bm25_item_if.sink            item_in,
    bm25_result_if.source        result_out,
    bm25_cfg_if.sink             cfg
);
    import bm25_pkg::*;

    localparam int CW     = (COUNT_BITS < DF_W) ? COUNT_BITS : DF_W;
    localparam int XW     = CW + 1;
    localparam int LGW    = $clog2(XW) + LOG_FRAC;
    localparam int IDW    = LGW + LN2_W - IDF_SHIFT;
    localparam int PL_W   = B_W + DOC_LEN_W - 1;
    localparam int D1_NW  = PL_W + 8;
    localparam int NORM_W = D1_NW + 1;
    localparam int NUM_W  = TF_W + K1_W + 1;
    localparam int KP_W   = K1_W + NORM_W;
    localparam int DEN_W  = KP_W + 1 - 16;
    localparam int D2_NW  = NUM_W + 24;
    localparam int TFC_W  = 29;
    localparam int PROD_W = IDW + TFC_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int SH     = 48 - SCORE_FRAC_BITS;
    localparam int MAG_W  = RND_W - SH;
    localparam int CMP_W  = (MAG_W > SCORE_W + 1) ? MAG_W : SCORE_W + 1;

    typedef struct packed {
        status_t           status;
        logic [TF_W-1:0]   tf;
        logic [PL_W-1:0]   pl;
    } log_side_t;

    typedef struct packed {
        status_t           status;
        logic [TF_W-1:0]   tf;
        logic [IDW-1:0]    idf;
        logic              neg;
    } d1_side_t;

    typedef struct packed {
        status_t           status;
        logic              zero_tf;
        logic [IDW-1:0]    idf;
        logic              neg;
    } d2_side_t;

    // Configuration registers.
    logic [K1_W-1:0]  k1_reg;
    logic [B_W-1:0]   b_reg;
    logic [AVG_W-1:0] avg_reg;
    logic [N_W-1:0]   n_reg;
    logic [B_W-1:0]   b_sat;

    assign cfg.ready = 1'b1;
    assign b_sat     = (b_reg > ONE_Q16) ? ONE_Q16 : b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg  <= K1_RESET;
            b_reg   <= B_RESET;
            avg_reg <= AVG_RESET;
            n_reg   <= N_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_TF_SAT:    k1_reg  <= cfg.data[K1_W-1:0];
                CFG_LEN_NORM:  b_reg   <= cfg.data[B_W-1:0];
                CFG_AVG_LEN:   avg_reg <= cfg.data[AVG_W-1:0];
                CFG_DOC_TOTAL: n_reg   <= cfg.data[N_W-1:0];
                default:       k1_reg  <= k1_reg;
            endcase
        end
    end

    // The whole pipeline advances together unless the skid stage is holding.
    logic adv;
    logic skid_valid_reg;
    assign adv           = !skid_valid_reg;
    assign item_in.ready = adv;

    // Stage 1: input register.
    logic                 v1_reg;
    logic [DOC_LEN_W-1:0] len1_reg;
    logic [TF_W-1:0]      tf1_reg;
    logic [CW-1:0]        df1_reg;

    // Stage 2: fault checks, log arguments, b*len.
    logic            v2_reg;
    status_t         status2_reg, status2_next;
    logic [TF_W-1:0] tf2_reg;
    logic [PL_W-1:0] pl2_reg, pl2_next;
    logic [XW-1:0]   xa2_reg, xa2_next, xb2_reg, xb2_next;
    logic [CW-1:0]   n_c;

    assign n_c = n_reg[CW-1:0];

    always_comb
    begin
        if (n_c == '0 || df1_reg == '0)
        begin
            status2_next = ST_ZERO_COUNT;
        end
        else if (avg_reg == '0)
        begin
            status2_next = ST_ZERO_AVG;
        end
        else if (df1_reg > n_c)
        begin
            status2_next = ST_DF_OVER_N;
        end
        else
        begin
            status2_next = ST_OK;
        end
        xa2_next = XW'(n_c) - XW'(df1_reg) + XW'(1);
        xb2_next = XW'(df1_reg) + XW'(1);
        // b <= 1.0 keeps b*len within PL_W bits.
        pl2_next = PL_W'(33'(b_sat) * 33'(len1_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= item_in.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len1_reg    <= item_in.doc_len;
            tf1_reg     <= item_in.tf_count;
            df1_reg     <= item_in.doc_freq[CW-1:0];
            status2_reg <= status2_next;
            tf2_reg     <= tf1_reg;
            pl2_reg     <= pl2_next;
            xa2_reg     <= xa2_next;
            xb2_reg     <= xb2_next;
        end
    end

    // log2 of both idf arguments.
    logic                   lg_valid;
    logic [LGW-1:0]         lg_a, lg_b;
    logic [$bits(log_side_t)-1:0] lg_side_bits;
    log_side_t              lg_side_in, lg_side;

    assign lg_side_in = '{status: status2_reg, tf: tf2_reg, pl: pl2_reg};
    assign lg_side    = log_side_t'(lg_side_bits);

    bm25_log2 #(
        .XW (XW),
        .SW ($bits(log_side_t))
    ) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v2_reg),
        .x_a       (xa2_reg),
        .x_b       (xb2_reg),
        .side_in   (lg_side_in),
        .out_valid (lg_valid),
        .log_a     (lg_a),
        .log_b     (lg_b),
        .side_out  (lg_side_bits)
    );

    // Stage 3: log difference with its sign. Stage 4: times ln 2.
    logic            v3_reg, v4_reg;
    logic [LGW-1:0]  diff3_reg, diff3_next;
    logic            neg3_reg, neg3_next;
    log_side_t       side3_reg, side4_reg;
    logic [IDW-1:0]  idf4_reg;
    logic            neg4_reg;
    logic [LGW+LN2_W-1:0] idf_prod;

    assign neg3_next  = (lg_b > lg_a);
    assign diff3_next = neg3_next ? (lg_b - lg_a) : (lg_a - lg_b);
    assign idf_prod   = (LGW+LN2_W)'(diff3_reg) * (LGW+LN2_W)'(LN2_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= lg_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff3_reg <= diff3_next;
            neg3_reg  <= neg3_next;
            side3_reg <= lg_side;
            idf4_reg  <= idf_prod[LGW+LN2_W-1:IDF_SHIFT];
            neg4_reg  <= neg3_reg;
            side4_reg <= side3_reg;
        end
    end

    // Length ratio: floor(b*len*2^8 / avg) in Q16.
    logic                 d1_valid;
    logic [D1_NW-1:0]     d1_quo;
    logic [$bits(d1_side_t)-1:0] d1_side_bits;
    d1_side_t             d1_side_in, d1_side;

    assign d1_side_in = '{status: side4_reg.status, tf: side4_reg.tf,
                          idf: idf4_reg, neg: neg4_reg};
    assign d1_side    = d1_side_t'(d1_side_bits);

    bm25_div #(
        .NW (D1_NW),
        .DW (AVG_W),
        .QW (D1_NW),
        .SW ($bits(d1_side_t))
    ) u_div_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v4_reg),
        .dividend  ({side4_reg.pl, 8'b0}),
        .divisor   (avg_reg),
        .side_in   (d1_side_in),
        .out_valid (d1_valid),
        .quotient  (d1_quo),
        .side_out  (d1_side_bits)
    );

    // Stage 5: norm and numerator. Stage 6: k1*norm. Stage 7: denominator in Q12.
    logic              v5_reg, v6_reg, v7_reg;
    logic [NORM_W-1:0] norm5_reg;
    logic [NUM_W-1:0]  num5_reg, num6_reg, num7_reg;
    d1_side_t          side5_reg, side6_reg, side7_reg;
    logic [KP_W-1:0]   kp6_reg;
    logic [DEN_W-1:0]  den7_reg;
    logic [KP_W:0]     den_sum;

    assign den_sum = ((KP_W+1)'(side6_reg.tf) << 28) + (KP_W+1)'(kp6_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (adv)
        begin
            v5_reg <= d1_valid;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            norm5_reg <= NORM_W'(ONE_Q16 - b_sat) + NORM_W'(d1_quo);
            num5_reg  <= NUM_W'(NUM_W'(d1_side.tf) * NUM_W'(K1_ONE + 17'(k1_reg)));
            side5_reg <= d1_side;
            kp6_reg   <= KP_W'(KP_W'(k1_reg) * KP_W'(norm5_reg));
            num6_reg  <= num5_reg;
            side6_reg <= side5_reg;
            den7_reg  <= den_sum[KP_W:16];
            num7_reg  <= num6_reg;
            side7_reg <= side6_reg;
        end
    end

    // tf component: (num << 24) / den, below 17.0 in Q24.
    logic                 d2_valid;
    logic [TFC_W-1:0]     tfc;
    logic [$bits(d2_side_t)-1:0] d2_side_bits;
    d2_side_t             d2_side_in, d2_side;

    assign d2_side_in = '{status: side7_reg.status, zero_tf: (side7_reg.tf == '0),
                          idf: side7_reg.idf, neg: side7_reg.neg};
    assign d2_side    = d2_side_t'(d2_side_bits);

    bm25_div #(
        .NW (D2_NW),
        .DW (DEN_W),
        .QW (TFC_W),
        .SW ($bits(d2_side_t))
    ) u_div_tf (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v7_reg),
        .dividend  ({num7_reg, 24'b0}),
        .divisor   (den7_reg),
        .side_in   (d2_side_in),
        .out_valid (d2_valid),
        .quotient  (tfc),
        .side_out  (d2_side_bits)
    );

    // Stage 8: idf * tfc. Stage 9: round half away from zero, saturate, apply sign.
    logic              v8_reg, v9_reg;
    logic [PROD_W-1:0] prod8_reg;
    d2_side_t          side8_reg;
    logic [SCORE_W-1:0] score9_reg, score9_next;
    status_t           status9_reg;
    logic [RND_W-1:0]  rnd;
    logic [CMP_W-1:0]  mag;

    always_comb
    begin
        rnd = RND_W'(prod8_reg) + (RND_W'(1) << (SH - 1));
        mag = CMP_W'(rnd[RND_W-1:SH]);
        if (side8_reg.neg)
        begin
            if (mag > CMP_W'(SCORE_MIN_MAG))
            begin
                mag = CMP_W'(SCORE_MIN_MAG);
            end
            score9_next = SCORE_W'(0) - mag[SCORE_W-1:0];
        end
        else
        begin
            if (mag > CMP_W'(SCORE_MAX_MAG))
            begin
                mag = CMP_W'(SCORE_MAX_MAG);
            end
            score9_next = mag[SCORE_W-1:0];
        end
        if (side8_reg.status != ST_OK || side8_reg.zero_tf)
        begin
            score9_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (adv)
        begin
            v8_reg <= d2_valid;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod8_reg   <= PROD_W'(PROD_W'(d2_side.idf) * PROD_W'(tfc));
            side8_reg   <= d2_side;
            score9_reg  <= score9_next;
            status9_reg <= side8_reg.status;
        end
    end

    // Output register with a skid stage behind it.
    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg, skid_score_reg;
    status_t            out_status_reg, skid_status_reg;
    logic               pop;

    assign pop = out_valid_reg && result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (v9_reg)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_score_reg  <= skid_score_reg;
                out_status_reg <= skid_status_reg;
            end
        end
        else if (v9_reg)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_score_reg  <= score9_reg;
                skid_status_reg <= status9_reg;
            end
            else
            begin
                out_score_reg  <= score9_reg;
                out_status_reg <= status9_reg;
            end
        end
    end

    assign result_out.valid  = out_valid_reg;
    assign result_out.score  = signed'(out_score_reg);
    assign result_out.status = out_status_reg;

    // A held transaction in the skid stage always has one in front of it.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // The skid stage only fills when the output was stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !result_out.ready))
        else $error("skid stage filled without an output stall");

    // Any fault status carries a zero score.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.status != STATUS_W'(ST_OK))
            |-> (result_out.score == '0))
        else $error("nonzero score reported with a fault status");
endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Testbench of the BM25 term scorer: directed and random term-document pairs
// are scored by an internal predictor and compared with the block's results.
// Depends on bm25_pkg, the three channel interfaces and bm25_term_score.
module testbench;
    import bm25_pkg::*;

    typedef struct {
        logic [DOC_LEN_W-1:0] doc_len;
        logic [TF_W-1:0]      tf_count;
        logic [DF_W-1:0]      doc_freq;
    } pair_t;

    typedef struct {
        logic [SCORE_W-1:0]  score;
        logic [STATUS_W-1:0] status;
    } score_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bm25_item_if   item_if ();
    bm25_result_if result_if ();
    bm25_cfg_if    cfg_if ();

    bm25_term_score u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    always #6 clk = ~clk;

    pair_t  pairs_to_send[$];
    score_t scores_due[$];
    int     error_count = 0;
    int     pairs_accepted = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    logic   hold_off = 1'b0;
    logic   pair_taken = 1'b0;

    // Register copies used by the predictor.
    logic [K1_W-1:0]  k1_reg  = K1_RESET;
    logic [B_W-1:0]   b_reg   = B_RESET;
    logic [AVG_W-1:0] avg_reg = AVG_RESET;
    logic [N_W-1:0]   n_reg   = N_RESET;

    // log2 with LOG_FRAC fraction bits: leading one, then repeated squaring.
    function automatic logic [63:0] log2_q(logic [63:0] x);
        logic [63:0] t;
        logic [63:0] m;
        logic [63:0] frac;
        int lead;
        t = x;
        lead = 0;
        frac = '0;
        while (t > 1)
        begin
            t = t >> 1;
            lead++;
        end
        if (lead <= 30)
            m = x << (30 - lead);
        else
            m = x >> (lead - 30);
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (64'(lead) << LOG_FRAC) | frac;
    endfunction

    function automatic score_t bm25_score(pair_t p);
        score_t r;
        logic [63:0] cmask, len, tf, df, n, k1, b;
        logic [63:0] norm, den, num, tfc, la, lb, diff, idf, mag;
        logic neg;
        cmask = (64'd1 << COUNT_BITS_DEF) - 1;
        len = 64'(p.doc_len);
        tf = 64'(p.tf_count);
        df = 64'(p.doc_freq) & cmask;
        n = 64'(n_reg) & cmask;
        k1 = 64'(k1_reg);
        b = (b_reg > ONE_Q16) ? 64'(ONE_Q16) : 64'(b_reg);
        r.score = '0;
        r.status = ST_OK;
        if (n == 0 || df == 0)
        begin
            r.status = ST_ZERO_COUNT;
            return r;
        end
        if (avg_reg == 0)
        begin
            r.status = ST_ZERO_AVG;
            return r;
        end
        if (df > n)
        begin
            r.status = ST_DF_OVER_N;
            return r;
        end
        norm = ((64'(ONE_Q16) - b) << 16) + ((b * len) << 24) / 64'(avg_reg);
        norm = norm >> 16;
        den = ((tf << 28) + k1 * norm) >> 16;
        num = tf * (k1 + 64'(K1_ONE));
        if (den == 0 || num == 0)
            return r;
        tfc = (num << 24) / den;
        la = log2_q(n - df + 1);
        lb = log2_q(df + 1);
        neg = lb > la;
        diff = neg ? lb - la : la - lb;
        idf = (diff * 64'(LN2_Q30)) >> IDF_SHIFT;
        mag = idf * tfc;
        mag = (mag + (64'd1 << (47 - SCORE_FRAC_BITS_DEF))) >> (48 - SCORE_FRAC_BITS_DEF);
        if (mag == 0)
            return r;
        if (neg)
        begin
            if (mag > SCORE_MIN_MAG)
                mag = SCORE_MIN_MAG;
            r.score = SCORE_W'(-mag);
        end
        else
        begin
            if (mag > SCORE_MAX_MAG)
                mag = SCORE_MAX_MAG;
            r.score = SCORE_W'(mag);
        end
        return r;
    endfunction

    // Input driver: a new pair is offered once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!item_if.valid || pair_taken))
        begin
            if (pairs_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pair_t p;
                p = pairs_to_send.pop_front();
                item_if.doc_len   <= p.doc_len;
                item_if.tf_count  <= p.tf_count;
                item_if.doc_freq  <= p.doc_freq;
                item_if.valid     <= 1'b1;
            end
            else
                item_if.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            result_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Acceptance of pairs and checking of scores.
    always @(posedge clk)
    begin
        pair_taken <= 1'b0;
        if (rst_n && item_if.valid && item_if.ready)
        begin
            pair_t p;
            p.doc_len = item_if.doc_len;
            p.tf_count = item_if.tf_count;
            p.doc_freq = item_if.doc_freq;
            scores_due.insert(scores_due.size(), bm25_score(p));
            pairs_accepted++;
            pair_taken <= 1'b1;
        end
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (scores_due.size() == 0)
            begin
                $error("result transaction with no score expected");
                error_count++;
            end
            else
            begin
                score_t e;
                e = scores_due.pop_front();
                if (result_if.score !== e.score)
                begin
                    $error("score: expected %0d, actual %0d", $signed(e.score),
                           $signed(result_if.score));
                    error_count++;
                end
                if (result_if.status !== e.status)
                begin
                    $error("status: expected %0d, actual %0d", e.status, result_if.status);
                    error_count++;
                end
            end
        end
    end

    // Long receiver stall so that the pipeline fills and stalls its input.
    initial
    begin
        wait (pairs_accepted >= 300);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("** bm25_term_score: FAILED **");
        $finish;
    end

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        case (idx)
            CFG_TF_SAT:    k1_reg = value[K1_W-1:0];
            CFG_LEN_NORM:  b_reg = value[B_W-1:0];
            CFG_AVG_LEN:   avg_reg = value[AVG_W-1:0];
            CFG_DOC_TOTAL: n_reg = value[N_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pairs_to_send.size() > 0 || item_if.valid || scores_due.size() > 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic add_pair(int len, int tf, int df);
        pair_t p;
        p.doc_len = DOC_LEN_W'(len);
        p.tf_count = TF_W'(tf);
        p.doc_freq = DF_W'(df);
        pairs_to_send.insert(pairs_to_send.size(), p);
    endtask

    // Mostly well-formed pairs with df in 1..N, plus faults and raw noise.
    task automatic add_random_pairs(int count);
        int kind, n, df, tf, len, avg_tokens;
        n = n_reg;
        avg_tokens = avg_reg >> 8;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 8)
                add_pair($urandom_range(65535), $urandom_range(65535),
                         $urandom_range(24'hFFFFFF));
            else if (kind < 14)
            begin
                df = (kind < 11 || n == 24'hFFFFFF) ? 0 : $urandom_range(24'hFFFFFF, n + 1);
                add_pair($urandom_range(65535), $urandom_range(65535), df);
            end
            else
            begin
                if (n == 0)
                    df = 0;
                else if (kind < 35)
                    df = $urandom_range((n < 16) ? n : 16, 1);
                else if (kind < 45)
                    df = $urandom_range(n, (n > 16) ? n - 16 : 1);
                else
                    df = $urandom_range(n, 1);
                tf = (kind < 85) ? $urandom_range(20) : $urandom_range(65535);
                if (kind % 3 == 0)
                    len = $urandom_range(65535);
                else
                    len = (avg_tokens + $urandom_range(200)) & 16'hFFFF;
                add_pair(len, tf, df);
            end
        end
    endtask

    initial
    begin
        item_if.valid = 1'b0;
        item_if.doc_len = '0;
        item_if.tf_count = '0;
        item_if.doc_freq = '0;
        result_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = CFG_TF_SAT;
        cfg_if.data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers at reset: counts are zero.
        add_pair(100, 3, 5);
        drain();
        // Average length still zero.
        write_reg(CFG_DOC_TOTAL, 1000);
        add_pair(100, 3, 5);
        add_pair(100, 3, 0);
        drain();
        // Directed cases with the default k1 and b.
        write_reg(CFG_AVG_LEN, 24'd200 << 8);
        add_pair(200, 3, 5);
        add_pair(200, 0, 5);
        add_pair(200, 3, 0);
        add_pair(200, 3, 1001);
        add_pair(200, 3, 1000);
        add_pair(200, 3, 1);
        add_pair(200, 3, 999);
        add_pair(0, 1, 10);
        add_pair(65535, 65535, 1);
        add_pair(65535, 1, 1000);
        add_pair(0, 65535, 500);
        add_pair(65535, 65535, 24'hFFFFFF);
        add_pair(1, 65535, 1);
        drain();
        // Largest collection, smallest average, b above one, zero k1.
        write_reg(CFG_DOC_TOTAL, 24'hFFFFFF);
        write_reg(CFG_AVG_LEN, 1);
        write_reg(CFG_LEN_NORM, 24'h1FFFF);
        write_reg(CFG_TF_SAT, 0);
        add_pair(65535, 65535, 1);
        add_pair(0, 1, 24'hFFFFFF);
        add_pair(65535, 1, 1);
        add_pair(1, 65535, 1);
        add_pair(65535, 0, 3);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            send_idle_pct = (ph < 4) ? 25 : (ph < 7) ? 64 : 0;
            recv_idle_pct = (ph < 4) ? 64 : (ph < 7) ? 25 : 0;
            case (ph)
                0: begin write_reg(CFG_TF_SAT, 65535); write_reg(CFG_LEN_NORM, 0); end
                1: begin write_reg(CFG_TF_SAT, 0); write_reg(CFG_LEN_NORM, 65536); end
                2: begin write_reg(CFG_TF_SAT, 4915); write_reg(CFG_LEN_NORM, 49152); end
                default:
                begin
                    write_reg(CFG_TF_SAT, $urandom_range(65535));
                    write_reg(CFG_LEN_NORM, $urandom_range(24'h1FFFF));
                end
            endcase
            case (ph)
                0: write_reg(CFG_AVG_LEN, 24'hFFFFFF);
                1: write_reg(CFG_AVG_LEN, 1);
                default: write_reg(CFG_AVG_LEN, $urandom_range(24'hFFFFFF, 256));
            endcase
            case (ph)
                0: write_reg(CFG_DOC_TOTAL, 1);
                1: write_reg(CFG_DOC_TOTAL, 24'hFFFFFF);
                2: write_reg(CFG_DOC_TOTAL, $urandom_range(100, 2));
                default: write_reg(CFG_DOC_TOTAL, $urandom_range(24'hFFFFFF, 1));
            endcase
            add_random_pairs(150);
            drain();
        end

        if (error_count == 0)
            $display("** bm25_term_score: PASSED **");
        else
            $display("** bm25_term_score: FAILED **");
        $finish;
    end
endmodule
